/* rtl/fpng_pkg.sv */
// ----------------------------------------------------------------------------
// fpng_pkg: shared constants and types for the frame peak normalizer
// Frame depth, field widths, register map and the output item record.
// ----------------------------------------------------------------------------
package fpng_pkg;

    // Frame store geometry
    localparam int FRAME_DEPTH = 64;
    localparam int FILL_W      = $clog2(FRAME_DEPTH + 1);
    localparam int ADDR_W      = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int TARGET_W = 15;
    localparam int MAG_W    = 16;
    localparam int NUM_W    = TARGET_W + 8 + 1;
    localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;

    // Q8 constants
    localparam logic [GAIN_W-1:0]   GAIN_ONE   = 16'd256;
    localparam logic [PROD_W-1:0]   ROUND_HALF = 33'd128;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7fff;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

    // Register map (word index taken from paddr[2])
    localparam logic REG_TARGET_LVL = 1'b0;
    localparam logic REG_MAX_GAIN   = 1'b1;

    // Register reset values
    localparam logic [TARGET_W-1:0] TARGET_RESET   = 15'd16384;
    localparam logic [GAIN_W-1:0]   MAX_GAIN_RESET = 16'd4096;

    // One result item
    typedef struct packed {
        logic [GAIN_W-1:0]   gain;
        logic                last;
        logic [SAMPLE_W-1:0] sample;
    } out_item_t;

endpackage

/* rtl/fpng_store.sv */
// ----------------------------------------------------------------------------
// fpng_store: frame sample memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fpng_store (
    input  logic                            aclk,
    input  logic                            wr_en,
    input  logic [fpng_pkg::ADDR_W-1:0]     wr_addr,
    input  logic [fpng_pkg::SAMPLE_W-1:0]   wr_data,
    input  logic                            rd_en,
    input  logic [fpng_pkg::ADDR_W-1:0]     rd_addr,
    output logic [fpng_pkg::SAMPLE_W-1:0]   rd_data
);
    import fpng_pkg::*;

    logic [SAMPLE_W-1:0] mem [FRAME_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/fpng_div.sv */
// ----------------------------------------------------------------------------
// fpng_div: iterative restoring divider for the frame gain
// One quotient bit per cycle; done pulses as the last bit enters the quotient register.
// ----------------------------------------------------------------------------
module fpng_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [fpng_pkg::NUM_W-1:0]   numer,
    input  logic [fpng_pkg::MAG_W-1:0]   denom,
    output logic                         done,
    output logic [fpng_pkg::NUM_W-1:0]   quot
);
    import fpng_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [MAG_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0] denom_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [MAG_W:0]   rem_sh;
    logic [MAG_W:0]   rem_sub;
    logic             ge;

    // one restoring step
    always_comb begin
        rem_sh  = {rem_reg, quot_reg[NUM_W-1]};
        ge      = (rem_sh >= {1'b0, denom_reg});
        rem_sub = rem_sh - {1'b0, denom_reg};
    end

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quot_next = numer;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quot_next = {quot_reg[NUM_W-2:0], ge};
            rem_next  = ge ? rem_sub[MAG_W-1:0] : rem_sh[MAG_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start) begin
            denom_reg <= denom;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* rtl/fpng_scale.sv */
// ----------------------------------------------------------------------------
// fpng_scale: gain multiply, round and saturate pipeline
// Stage 1 registers the product, stage 2 is the output register.
// All stages advance together on en.
// ----------------------------------------------------------------------------
module fpng_scale (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic                            in_last,
    input  logic [fpng_pkg::SAMPLE_W-1:0]   in_sample,
    input  logic [fpng_pkg::GAIN_W-1:0]     gain,
    output logic                            out_valid,
    output fpng_pkg::out_item_t             out_item
);
    import fpng_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     prod_valid_reg;
    logic                     prod_last_reg;
    logic [GAIN_W-1:0]        prod_gain_reg;

    logic                     out_valid_reg;
    out_item_t                out_item_reg;
    out_item_t                out_item_next;

    logic signed [SAMPLE_W-1:0] s_signed;
    logic signed [GAIN_W:0]     g_signed;
    logic                       neg;
    logic [PROD_W-1:0]          mag;
    logic [PROD_W-1:0]          mag_rnd;
    logic [PROD_W-9:0]          q;

    // product of signed sample and unsigned gain
    always_comb begin
        s_signed  = in_sample;
        g_signed  = {1'b0, gain};
        prod_next = PROD_W'(s_signed) * PROD_W'(g_signed);
    end

    // round half away from zero, divide by 256, saturate
    always_comb begin
        neg     = prod_reg[PROD_W-1];
        mag     = neg ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        mag_rnd = mag + ROUND_HALF;
        q       = mag_rnd[PROD_W-1:8];
        out_item_next.gain = prod_gain_reg;
        out_item_next.last = prod_last_reg;
        if (!neg) begin
            if (q > (PROD_W-8)'(SAMPLE_MAX)) begin
                out_item_next.sample = SAMPLE_MAX;
            end else begin
                out_item_next.sample = q[SAMPLE_W-1:0];
            end
        end else begin
            if (q > (PROD_W-8)'(SAMPLE_MIN)) begin
                out_item_next.sample = SAMPLE_MIN;
            end else begin
                out_item_next.sample = -q[SAMPLE_W-1:0];
            end
        end
    end

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else if (en) begin
            prod_valid_reg <= in_valid;
            out_valid_reg  <= prod_valid_reg;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg      <= prod_next;
            prod_last_reg <= in_last;
            prod_gain_reg <= gain;
            out_item_reg  <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* rtl/frame_peak_normalize_gain.sv */
// ----------------------------------------------------------------------------
// frame_peak_normalize_gain: frame peak normalizer with Q8 automatic gain
//
// Input stream (s_*): one signed 16-bit sample per request, s_tlast ends a
// frame; a frame also ends when 64 samples are stored. Output stream (m_*):
// every stored sample times the frame gain, rounded half away from zero
// and saturated, with the gain beside it; m_tlast marks the frame's last.
// Samples are accepted one per cycle while loading (s_tready high). After
// the last sample the gain is computed by a bit-serial divider (skipped
// for a silent frame, which takes max_gain, or unity if max_gain is lower).
// Samples are then read back from the frame memory one per cycle, while
// the output is not stalled, through a 3-stage read, multiply and round
// pipeline. The next frame is accepted once the last result is taken.
// m_tready low while a result is waiting freezes the whole read pipeline;
// nothing is dropped. Reset (aresetn low, synchronous) empties the frame
// and loads a target level of 16384 and max_gain = 4096. Registers are
// written over APB at 0x0 (target level) and 0x4 (max_gain); the user
// must write them only while the block is idle; the block does not check.
// ----------------------------------------------------------------------------
module frame_peak_normalize_gain (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] in_sample
    input  logic        s_tlast,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [15:0] out_sample, [31:16] applied_gain
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fpng_pkg::*;

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_START = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [MAG_W-1:0]    peak_reg, peak_next;
    logic [GAIN_W-1:0]   gain_reg, gain_next;
    logic [FILL_W-1:0]   issue_reg, issue_next;
    logic [TARGET_W-1:0] target_reg;
    logic [GAIN_W-1:0]   max_gain_reg;
    logic                rd_valid_reg;
    logic                rd_last_reg;

    logic                in_acc;
    logic                cfg_wr;
    logic [SAMPLE_W-1:0] in_sample;
    logic [MAG_W-1:0]    in_mag;
    logic                frame_end;
    logic [GAIN_W-1:0]   gain_hi;
    logic [NUM_W-1:0]    div_numer;
    logic                div_start;
    logic                div_done;
    logic [NUM_W-1:0]    div_quot;
    logic                advance;
    logic                issue;
    logic                issue_last;
    logic [SAMPLE_W-1:0] rd_data;
    logic                sc_valid;
    out_item_t           sc_item;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg   <= TARGET_RESET;
            max_gain_reg <= MAX_GAIN_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_TARGET_LVL: target_reg   <= pwdata[TARGET_W-1:0];
                REG_MAX_GAIN:   max_gain_reg <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TARGET_LVL: prdata = 32'(target_reg);
            REG_MAX_GAIN:   prdata = 32'(max_gain_reg);
            default:        prdata = '0;
        endcase
    end

    // input side
    assign s_tready  = (state_reg == ST_LOAD);
    assign in_acc    = s_tvalid & s_tready;
    assign in_sample = s_tdata;
    assign in_mag    = in_sample[SAMPLE_W-1] ? (~in_sample + 1'b1) : in_sample;
    assign frame_end = s_tlast | (fill_reg == FILL_W'(FRAME_DEPTH - 1));

    // gain limits and divider operands
    assign gain_hi   = (max_gain_reg < GAIN_ONE) ? GAIN_ONE : max_gain_reg;
    assign div_numer = {1'b0, target_reg, 8'd0} + NUM_W'(peak_reg >> 1);
    assign div_start = (state_reg == ST_START) && (peak_reg != '0);

    // read pipeline control
    assign advance    = ~sc_valid | m_tready;
    assign issue      = (state_reg == ST_EMIT) && advance && (issue_reg != fill_reg);
    assign issue_last = (issue_reg == fill_reg - 1'b1);

    // sequencer
    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        peak_next  = peak_reg;
        gain_next  = gain_reg;
        issue_next = issue_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_acc) begin
                    fill_next = fill_reg + 1'b1;
                    if (in_mag > peak_reg) begin
                        peak_next = in_mag;
                    end
                    if (frame_end) begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                if (peak_reg == '0) begin
                    gain_next  = gain_hi;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (div_quot < NUM_W'(GAIN_ONE)) begin
                        gain_next = GAIN_ONE;
                    end else if (div_quot > NUM_W'(gain_hi)) begin
                        gain_next = gain_hi;
                    end else begin
                        gain_next = div_quot[GAIN_W-1:0];
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (issue) begin
                    issue_next = issue_reg + 1'b1;
                end
                if (sc_valid && m_tready && sc_item.last) begin
                    fill_next  = '0;
                    peak_next  = '0;
                    issue_next = '0;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            fill_reg     <= '0;
            peak_reg     <= '0;
            issue_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            peak_reg  <= peak_next;
            issue_reg <= issue_next;
            if (advance) begin
                rd_valid_reg <= issue;
            end
        end
    end

    always_ff @(posedge aclk) begin
        gain_reg <= gain_next;
        if (advance) begin
            rd_last_reg <= issue_last;
        end
    end

    // frame memory
    fpng_store u_store (
        .aclk    (aclk),
        .wr_en   (in_acc),
        .wr_addr (fill_reg[ADDR_W-1:0]),
        .wr_data (in_sample),
        .rd_en   (issue),
        .rd_addr (issue_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // gain divider
    fpng_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_numer),
        .denom   (peak_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // multiply, round, saturate, output register
    fpng_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .in_valid  (rd_valid_reg),
        .in_last   (rd_last_reg),
        .in_sample (rd_data),
        .gain      (gain_reg),
        .out_valid (sc_valid),
        .out_item  (sc_item)
    );

    assign m_tvalid = sc_valid;
    assign m_tdata  = {sc_item.gain, sc_item.sample};
    assign m_tlast  = sc_item.last;

endmodule

/* test/frame_peak_normalize_gain_tb.sv */
// ----------------------------------------------------------------------------
// frame_peak_normalize_gain_tb: self-checking bench for the peak normalizer
//
// Streams frames of signed PCM samples into the block and checks every
// scaled sample, its frame-end flag and the applied Q8 gain.
// A directed table comes first: silent frames, full-scale peaks, rounding
// ties, saturation and the register extremes.
// Random frames follow under three handshake pressure profiles, including
// frames that fill the store without a last flag and one long output stall.
// ----------------------------------------------------------------------------
module frame_peak_normalize_gain_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fpng_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int DRAIN_CYCLES = 60;       // gain divide plus read pipeline
    localparam int HOLD_CYCLES  = 400;      // long output back-pressure stretch
    localparam int PHASE_ITEMS  = 45;
    localparam int MAX_REPORTS  = 10;

    typedef enum logic {ROW_DATA, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic               reg_sel;    // register for ROW_WRITE
        int                 value;
        logic signed [15:0] smp;
        logic               lst;
        bit                 typed;      // expected single result given below
        logic signed [15:0] exp_smp;
        logic [15:0]        exp_gain;
    } stim_row_t;

    localparam int N_DIR = 30;

    // Directed table: typed rows are single-sample frames whose result is obvious
    stim_row_t dir_rows [N_DIR] = '{
        // reset registers: target 16384, max gain 4096
        '{ROW_DATA,  REG_TARGET_LVL, 0, 16'sd0,      1'b1, 1'b1, 16'sd0,      16'd4096},
        '{ROW_DATA,  REG_TARGET_LVL, 0, -16'sd32768, 1'b1, 1'b1, -16'sd32768, 16'd256},
        '{ROW_DATA,  REG_TARGET_LVL, 0, 16'sd32767,  1'b1, 1'b1, 16'sd32767,  16'd256},
        '{ROW_DATA,  REG_TARGET_LVL, 0, 16'sd1,      1'b1, 1'b1, 16'sd16,     16'd4096},
        '{ROW_DATA,  REG_TARGET_LVL, 0, -16'sd1,     1'b1, 1'b1, -16'sd16,    16'd4096},
        '{ROW_DATA,  REG_TARGET_LVL, 0, 16'sd100,    1'b0, 1'b0, 16'sd0,      16'd0},
        '{ROW_DATA,  REG_TARGET_LVL, 0, -16'sd200,   1'b0, 1'b0, 16'sd0,      16'd0},
        '{ROW_DATA,  REG_TARGET_LVL, 0, 16'sd50,     1'b1, 1'b0, 16'sd0,      16'd0},
        // non-power-of-two gain (1398) from the divider
        '{ROW_DATA,  REG_TARGET_LVL, 0, 16'sd3000,   1'b0, 1'b0, 16'sd0,      16'd0},
        '{ROW_DATA,  REG_TARGET_LVL, 0, -16'sd3,     1'b0, 1'b0, 16'sd0,      16'd0},
        '{ROW_DATA,  REG_TARGET_LVL, 0, 16'sd7,      1'b1, 1'b0, 16'sd0,      16'd0},
        // gain 384: every odd sample lands on a rounding tie
        '{ROW_DATA,  REG_TARGET_LVL, 0, 16'sd10923,  1'b0, 1'b0, 16'sd0,      16'd0},
        '{ROW_DATA,  REG_TARGET_LVL, 0, 16'sd1,      1'b0, 1'b0, 16'sd0,      16'd0},
        '{ROW_DATA,  REG_TARGET_LVL, 0, -16'sd1,     1'b0, 1'b0, 16'sd0,      16'd0},
        '{ROW_DATA,  REG_TARGET_LVL, 0, 16'sd3,      1'b1, 1'b0, 16'sd0,      16'd0},
        // upper register extremes
        '{ROW_WRITE, REG_TARGET_LVL, 32767, 16'sd0,  1'b0, 1'b0, 16'sd0,      16'd0},
        '{ROW_WRITE, REG_MAX_GAIN,   65535, 16'sd0,  1'b0, 1'b0, 16'sd0,      16'd0},
        // gain 512 pushes +16384 past full scale
        '{ROW_DATA,  REG_TARGET_LVL, 0, 16'sd16384,  1'b0, 1'b0, 16'sd0,      16'd0},
        '{ROW_DATA,  REG_TARGET_LVL, 0, -16'sd16384, 1'b1, 1'b0, 16'sd0,      16'd0},
        '{ROW_DATA,  REG_TARGET_LVL, 0, 16'sd3,      1'b1, 1'b1, 16'sd768,    16'd65535},
        '{ROW_DATA,  REG_TARGET_LVL, 0, 16'sd0,      1'b1, 1'b1, 16'sd0,      16'd65535},
        // zero target and max gain below unity both clamp to 256
        '{ROW_WRITE, REG_TARGET_LVL, 0, 16'sd0,      1'b0, 1'b0, 16'sd0,      16'd0},
        '{ROW_WRITE, REG_MAX_GAIN,   0, 16'sd0,      1'b0, 1'b0, 16'sd0,      16'd0},
        '{ROW_DATA,  REG_TARGET_LVL, 0, 16'sd0,      1'b1, 1'b1, 16'sd0,      16'd256},
        '{ROW_DATA,  REG_TARGET_LVL, 0, 16'sd5,      1'b1, 1'b1, 16'sd5,      16'd256},
        '{ROW_DATA,  REG_TARGET_LVL, 0, -16'sd32768, 1'b0, 1'b0, 16'sd0,      16'd0},
        '{ROW_DATA,  REG_TARGET_LVL, 0, 16'sd32767,  1'b1, 1'b0, 16'sd0,      16'd0},
        // lower in-range extremes
        '{ROW_WRITE, REG_TARGET_LVL, 1, 16'sd0,      1'b0, 1'b0, 16'sd0,      16'd0},
        '{ROW_WRITE, REG_MAX_GAIN,   256, 16'sd0,    1'b0, 1'b0, 16'sd0,      16'd0},
        '{ROW_DATA,  REG_TARGET_LVL, 0, 16'sd1,      1'b1, 1'b1, 16'sd1,      16'd256}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;     // [15:0] in_sample
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;     // [15:0] out_sample, [31:16] applied_gain
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Handshake pressure knobs
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req    = 1'b0;

    // Predictor state and expected output store
    int        open_frame[$];
    int        peak_mag   = 0;
    int        target_cfg = int'(TARGET_RESET);
    int        gain_cfg   = int'(MAX_GAIN_RESET);
    out_item_t scaled_q[$];

    int n_errors  = 0;
    int n_items   = 0;
    int n_frames  = 0;
    int n_results = 0;
    int n_writes  = 0;

    frame_peak_normalize_gain u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Frame model: collect samples, then scale the whole frame by its gain
    function automatic void normalize_sample(logic signed [15:0] smp, logic lst);
        int        s;
        int        mag;
        int        hi;
        int        g;
        longint    prod;
        longint    q;
        out_item_t item;
        s   = smp;
        mag = (s < 0) ? -s : s;
        open_frame.push_back(s);
        if (mag > peak_mag) peak_mag = mag;
        if (!lst && open_frame.size() < FRAME_DEPTH) return;

        hi = (gain_cfg < int'(GAIN_ONE)) ? int'(GAIN_ONE) : gain_cfg;
        if (peak_mag == 0) begin
            g = hi;
        end else begin
            g = (target_cfg * int'(GAIN_ONE) + peak_mag / 2) / peak_mag;
            if (g < int'(GAIN_ONE)) g = int'(GAIN_ONE);
            else if (g > hi) g = hi;
        end

        foreach (open_frame[k]) begin
            prod = longint'(open_frame[k]) * g;
            q    = ((prod < 0 ? -prod : prod) + longint'(ROUND_HALF)) / int'(GAIN_ONE);
            if (prod < 0) q = -q;
            if (q > longint'($signed(SAMPLE_MAX))) q = longint'($signed(SAMPLE_MAX));
            else if (q < longint'($signed(SAMPLE_MIN))) q = longint'($signed(SAMPLE_MIN));
            item.sample = q[15:0];
            item.last   = (k == open_frame.size() - 1);
            item.gain   = g[15:0];
            scaled_q.push_back(item);
        end
        open_frame.delete();
        peak_mag = 0;
        n_frames++;
    endfunction

    // Offer one sample, with random idle cycles ahead of it; returns at a falling edge
    task automatic push_sample(input logic signed [15:0] smp, input logic lst);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = smp;
        s_tlast  = lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        normalize_sample(smp, lst);
        n_items++;
        @(negedge aclk);
    endtask

    // Let every pending result drain, then give the divider time to settle
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (scaled_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // APB write: setup then access phase
    task automatic apb_write(input logic reg_sel, input int value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_sel, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (reg_sel == REG_TARGET_LVL) target_cfg = value & 32'h7fff;
        else                           gain_cfg   = value & 32'hffff;
        n_writes++;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic logic signed [15:0] rand_sample();
        logic signed [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(15))
            0:       return $signed(SAMPLE_MIN);
            1:       return $signed(SAMPLE_MAX);
            2:       return 16'sd0;
            default: return v >>> $urandom_range(15);
        endcase
    endfunction

    // One random phase: fresh registers, then whole frames until the item budget is spent
    task automatic random_phase(input int tx_pct, input int rx_pct, input bit fill_first,
                                input bit long_hold);
        int start_items;
        int len;
        bit no_last;
        int tgt;
        int mgain;
        wait_drained();
        case ($urandom_range(3))
            0:       tgt = 32767;
            1:       tgt = 1;
            default: tgt = $urandom_range(32767);
        endcase
        case ($urandom_range(3))
            0:       mgain = 65535;
            1:       mgain = 256;
            default: mgain = $urandom_range(65535);
        endcase
        apb_write(REG_TARGET_LVL, tgt);
        apb_write(REG_MAX_GAIN, mgain);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        if (long_hold) hold_req = 1'b1;
        start_items = n_items;
        while (n_items - start_items < PHASE_ITEMS) begin
            // frame shape: full store with or without last, else a short frame
            case ((fill_first && n_items == start_items) ? 0 : $urandom_range(13))
                0:       begin len = FRAME_DEPTH; no_last = 1'b1; end
                1:       begin len = FRAME_DEPTH; no_last = 1'b0; end
                default: begin len = $urandom_range(1, 8); no_last = 1'b0; end
            endcase
            for (int k = 0; k < len; k++)
                push_sample(rand_sample(), !no_last && (k == len - 1));
        end
    endtask

    // Output side back-pressure, with one long hold on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (scaled_q.size() == 0) begin
                if (n_errors < MAX_REPORTS)
                    $display("%0t: unexpected result sample=%0d last=%0b gain=%0d", $realtime,
                             $signed(m_tdata[15:0]), m_tlast, m_tdata[31:16]);
                n_errors++;
            end else begin
                want = scaled_q.pop_front();
                if (m_tdata[15:0] !== want.sample || m_tlast !== want.last ||
                    m_tdata[31:16] !== want.gain) begin
                    if (n_errors < MAX_REPORTS)
                        $display("%0t: mismatch exp sample=%0d last=%0b gain=%0d, got %0d %0b %0d",
                                 $realtime, $signed(want.sample), want.last, want.gain,
                                 $signed(m_tdata[15:0]), m_tlast, m_tdata[31:16]);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        #(2_400_000);
        $display("timeout with %0d results outstanding", scaled_q.size());
        $display("frame_peak_normalize_gain_tb: errors");
        $finish;
    end

    // Main sequence
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE) begin
                wait_drained();
                apb_write(dir_rows[i].reg_sel, dir_rows[i].value);
            end else begin
                push_sample(dir_rows[i].smp, dir_rows[i].lst);
                if (dir_rows[i].typed)
                    scaled_q[$] = '{gain: dir_rows[i].exp_gain, last: 1'b1,
                                    sample: dir_rows[i].exp_smp};
            end
        end

        // random frames under three pressure profiles
        random_phase(30, 65, 1'b1, 1'b0);
        random_phase(65, 30, 1'b0, 1'b0);
        random_phase(0, 0, 1'b0, 1'b1);

        wait_drained();
        $display("covered %0d samples in %0d frames, %0d results compared, %0d register writes",
                 n_items, n_frames, n_results, n_writes);
        $display("included full-store frames, silent frames, clamped gains and a long stall");
        if (n_errors == 0) begin
            $display("frame_peak_normalize_gain_tb: clean");
        end else begin
            $display("%0d failures", n_errors);
            $display("frame_peak_normalize_gain_tb: errors");
        end
        $finish;
    end

endmodule
